[hdl/assert_macros.svh]
// assertion helpers used by the checker file brg_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/brg_pkg.sv]
// ----------------------------------------------------------------------------
// brg_pkg
// types and constants shared by the version rollback guard modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brg_pkg;

  typedef enum logic [2:0] {
    FN_CHECK_UPDATE = 3'd0,
    FN_INCREMENT    = 3'd1,
    FN_GET_VERSION  = 3'd2,
    FN_MARK_DELETED = 3'd3,
    FN_SHOULD_EXIST = 3'd4
  } brg_func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REJECT   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_INVALID  = 3'd5
  } brg_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DECIDE
  } brg_state_e;

  localparam logic CFG_OWN_CLIENT = 1'b0;
  localparam logic CFG_DEL_MARKER = 1'b1;

  localparam logic [63:0] VER_LIMIT = 64'hFFFF_FFFF_FFFF_FFFE;

  typedef struct packed {
    logic [31:0] client;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value;
  } brg_ver_ent_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [31:0] client;
  } brg_wr_ent_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
  } brg_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } brg_sts_t;

endpackage

[hdl/brg_ctrl.sv]
// ----------------------------------------------------------------------------
// brg_ctrl
// sequencer: accept a request, scan both tables, commit and hand off result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  brg_pkg::brg_sts_t sts_i,
  output brg_pkg::brg_cmd_t cmd_o
);

  brg_pkg::brg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= brg_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      brg_pkg::S_IDLE: begin
        if (in_valid_i) state_d = brg_pkg::S_SCAN;
      end
      brg_pkg::S_SCAN: begin
        if (sts_i.scan_done) state_d = brg_pkg::S_WAIT;
      end
      brg_pkg::S_WAIT: begin
        state_d = brg_pkg::S_DECIDE;
      end
      brg_pkg::S_DECIDE: begin
        if (sts_i.out_free) state_d = brg_pkg::S_IDLE;
      end
      default: state_d = brg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      brg_pkg::S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.start  = in_valid_i;
      end
      brg_pkg::S_SCAN: begin
        cmd_o.scan = !sts_i.scan_done;
      end
      brg_pkg::S_WAIT: begin
      end
      brg_pkg::S_DECIDE: begin
        cmd_o.decide = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/brg_dp.sv]
// ----------------------------------------------------------------------------
// brg_dp
// datapath: request registers, table memories, scan compare and commit logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brg_dp #(
  parameter int VERSION_ENTRIES = 256,
  parameter int WRITER_ENTRIES  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  brg_pkg::brg_cmd_t cmd_i,
  output brg_pkg::brg_sts_t sts_o,
  input  logic [31:0]       own_client_id_i,
  input  logic [31:0]       deleted_marker_id_i,
  input  logic [2:0]        func_i,
  input  logic [31:0]       client_id_i,
  input  logic [63:0]       key_high_i,
  input  logic [63:0]       key_low_i,
  input  logic [63:0]       version_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic              flag_out_o,
  output logic [63:0]       version_out_o
);

  localparam int MAXE = (VERSION_ENTRIES > WRITER_ENTRIES) ? VERSION_ENTRIES : WRITER_ENTRIES;
  localparam int VAW  = $clog2(VERSION_ENTRIES);
  localparam int VCW  = $clog2(VERSION_ENTRIES + 1);
  localparam int WAW  = $clog2(WRITER_ENTRIES);
  localparam int WCW  = $clog2(WRITER_ENTRIES + 1);
  localparam int SCW  = $clog2(MAXE + 1);

  brg_pkg::brg_ver_ent_t ver_mem [VERSION_ENTRIES];
  brg_pkg::brg_wr_ent_t  wr_mem  [WRITER_ENTRIES];

  // request
  logic [2:0]  func_q;
  logic [31:0] cid_q;
  logic [63:0] kh_q, kl_q, ver_q;

  // scan
  logic [VCW-1:0] ver_cnt_q;
  logic [WCW-1:0] wr_cnt_q;
  logic [SCW-1:0] idx_q, rd_idx_q, scan_end;
  logic           v_rd_en, w_rd_en, v_rv_q, w_rv_q;
  brg_pkg::brg_ver_ent_t ver_rd_q;
  brg_pkg::brg_wr_ent_t  wr_rd_q;
  logic           vhit_q, whit_q, v_match, w_match;
  logic [VAW-1:0] vslot_q;
  logic [WAW-1:0] wslot_q;
  logic [63:0]    vval_q;
  logic [31:0]    wcli_q;

  // commit
  logic           vfree, wfree, ver_we, wr_we;
  logic [VAW-1:0] ver_wa;
  logic [WAW-1:0] wr_wa;
  brg_pkg::brg_ver_ent_t ver_wd;
  brg_pkg::brg_wr_ent_t  wr_wd;
  logic [63:0]    known, base, nv;
  logic [2:0]     res_status;
  logic           res_flag;
  logic [63:0]    res_vout;
  logic           out_valid_q;
  logic [2:0]     status_q;
  logic           flag_q;
  logic [63:0]    vout_q;

  assign scan_end = (SCW'(ver_cnt_q) > SCW'(wr_cnt_q)) ? SCW'(ver_cnt_q) : SCW'(wr_cnt_q);
  assign v_rd_en  = cmd_i.scan && (idx_q < SCW'(ver_cnt_q));
  assign w_rd_en  = cmd_i.scan && (idx_q < SCW'(wr_cnt_q));

  assign sts_o.scan_done = (idx_q >= scan_end);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign v_match = v_rv_q && !vhit_q && (ver_rd_q.client == cid_q)
                   && (ver_rd_q.key_high == kh_q) && (ver_rd_q.key_low == kl_q);
  assign w_match = w_rv_q && !whit_q
                   && (wr_rd_q.key_high == kh_q) && (wr_rd_q.key_low == kl_q);

  always_ff @(posedge clk_i) begin
    if (ver_we) ver_mem[ver_wa] <= ver_wd;
    if (v_rd_en) ver_rd_q <= ver_mem[idx_q[VAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_we) wr_mem[wr_wa] <= wr_wd;
    if (w_rd_en) wr_rd_q <= wr_mem[idx_q[WAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= func_i;
      cid_q  <= (func_i == brg_pkg::FN_INCREMENT) ? own_client_id_i : client_id_i;
      kh_q   <= key_high_i;
      kl_q   <= key_low_i;
      ver_q  <= version_in_i;
    end
    if (cmd_i.scan) rd_idx_q <= idx_q;
    if (v_match) begin
      vslot_q <= rd_idx_q[VAW-1:0];
      vval_q  <= ver_rd_q.value;
    end
    if (w_match) begin
      wslot_q <= rd_idx_q[WAW-1:0];
      wcli_q  <= wr_rd_q.client;
    end
    if (cmd_i.decide) begin
      status_q <= res_status;
      flag_q   <= res_flag;
      vout_q   <= res_vout;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_cnt_q   <= '0;
      wr_cnt_q    <= '0;
      idx_q       <= '0;
      v_rv_q      <= 1'b0;
      w_rv_q      <= 1'b0;
      vhit_q      <= 1'b0;
      whit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v_rv_q <= v_rd_en;
      w_rv_q <= w_rd_en;
      if (cmd_i.start) begin
        idx_q  <= '0;
        vhit_q <= 1'b0;
        whit_q <= 1'b0;
      end else begin
        if (cmd_i.scan) idx_q <= idx_q + SCW'(1);
        if (v_match) vhit_q <= 1'b1;
        if (w_match) whit_q <= 1'b1;
      end
      if (ver_we && !vhit_q) ver_cnt_q <= ver_cnt_q + VCW'(1);
      if (wr_we && !whit_q) wr_cnt_q <= wr_cnt_q + WCW'(1);
      if (cmd_i.decide) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign vfree = (ver_cnt_q != VCW'(VERSION_ENTRIES));
  assign wfree = (wr_cnt_q != WCW'(WRITER_ENTRIES));
  assign known = vhit_q ? vval_q : 64'd0;
  assign base  = (ver_q > known) ? ver_q : known;
  assign nv    = base + 64'd1;

  always_comb begin
    logic do_ver, do_wr, ok_flag;
    logic [63:0] v_value;
    logic [31:0] w_client;
    do_ver     = 1'b0;
    do_wr      = 1'b0;
    ok_flag    = 1'b0;
    v_value    = ver_q;
    w_client   = cid_q;
    res_status = brg_pkg::ST_OK;
    res_flag   = 1'b0;
    res_vout   = '0;
    unique case (func_q)
      brg_pkg::FN_CHECK_UPDATE: begin
        if (cid_q == deleted_marker_id_i || ver_q == 64'd0) begin
          res_status = brg_pkg::ST_INVALID;
        end else if (!vhit_q && !vfree) begin
          res_status = brg_pkg::ST_FULL;
        end else if (vhit_q && known > ver_q) begin
          res_status = brg_pkg::ST_REJECT;
        end else if (!whit_q && !wfree) begin
          res_status = brg_pkg::ST_FULL;
        end else if (whit_q && known == ver_q && wcli_q != cid_q) begin
          res_status = brg_pkg::ST_REJECT;
        end else begin
          do_ver  = 1'b1;
          do_wr   = 1'b1;
          ok_flag = 1'b1;
        end
        res_flag = ok_flag;
      end
      brg_pkg::FN_INCREMENT: begin
        if (!vhit_q && !vfree) begin
          res_status = brg_pkg::ST_FULL;
        end else if (base >= brg_pkg::VER_LIMIT) begin
          res_status = brg_pkg::ST_OVERFLOW;
          do_ver     = !vhit_q;
          v_value    = 64'd0;
        end else if (!whit_q && !wfree) begin
          res_status = brg_pkg::ST_FULL;
        end else begin
          do_ver   = 1'b1;
          do_wr    = 1'b1;
          v_value  = nv;
          res_vout = nv;
        end
      end
      brg_pkg::FN_GET_VERSION: begin
        if (vhit_q) res_vout = vval_q;
        else res_status = brg_pkg::ST_NOTFOUND;
      end
      brg_pkg::FN_MARK_DELETED: begin
        if (!whit_q && !wfree) begin
          res_status = brg_pkg::ST_FULL;
        end else begin
          do_wr    = 1'b1;
          w_client = deleted_marker_id_i;
        end
      end
      brg_pkg::FN_SHOULD_EXIST: begin
        res_flag = whit_q && (wcli_q != deleted_marker_id_i);
      end
      default: res_status = brg_pkg::ST_INVALID;
    endcase
    ver_we          = cmd_i.decide && do_ver;
    wr_we           = cmd_i.decide && do_wr;
    ver_wa          = vhit_q ? vslot_q : ver_cnt_q[VAW-1:0];
    wr_wa           = whit_q ? wslot_q : wr_cnt_q[WAW-1:0];
    ver_wd.client   = cid_q;
    ver_wd.key_high = kh_q;
    ver_wd.key_low  = kl_q;
    ver_wd.value    = v_value;
    wr_wd.key_high  = kh_q;
    wr_wd.key_low   = kl_q;
    wr_wd.client    = w_client;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign flag_out_o    = flag_q;
  assign version_out_o = vout_q;

endmodule

[hdl/block_version_rollback_guard_core.sv]
// ----------------------------------------------------------------------------
// block_version_rollback_guard_core
// anti-rollback version table with apb configuration
// ----------------------------------------------------------------------------
// usage:
//   requests enter on in_valid_i/in_stall_o with func_i, client_id_i, key and
//   version_in_i; one result per request leaves on out_valid_o/out_stall_i
//   with status_o, flag_out_o and version_out_o
//   each request scans both tables one entry per cycle through their memory
//   read ports; the result is registered at the commit step after the scan, and
//   a new request is taken only once the previous one has committed
//   a finished result waits in the output register while the next request
//   is scanned; when the receiver stalls, the result holds and the block
//   stalls its input at the commit step until the output register frees
//   reset empties both tables at once (fill counts go to zero), sets
//   own_client_id to 1 and deleted_marker_id to 0
//   registers: own_client_id at 0x0, deleted_marker_id at 0x4, to be written
//   by the user (the block does not check) only while no request is in flight
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_version_rollback_guard_core #(
  parameter int VERSION_ENTRIES = 256,
  parameter int WRITER_ENTRIES  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] client_id_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  input  logic [63:0] version_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        flag_out_o,
  output logic [63:0] version_out_o
);

  logic [31:0] own_q, del_q;
  logic        cfg_we;
  brg_pkg::brg_cmd_t cmd;
  brg_pkg::brg_sts_t sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= 32'd1;
      del_q <= 32'd0;
    end else if (cfg_we) begin
      if (paddr[2] == brg_pkg::CFG_OWN_CLIENT) own_q <= pwdata;
      else del_q <= pwdata;
    end
  end

  always_comb begin
    unique case (paddr[2])
      brg_pkg::CFG_OWN_CLIENT: prdata = own_q;
      brg_pkg::CFG_DEL_MARKER: prdata = del_q;
      default:                 prdata = '0;
    endcase
  end

  brg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  brg_dp #(
    .VERSION_ENTRIES (VERSION_ENTRIES),
    .WRITER_ENTRIES  (WRITER_ENTRIES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .own_client_id_i     (own_q),
    .deleted_marker_id_i (del_q),
    .func_i              (func_i),
    .client_id_i         (client_id_i),
    .key_high_i          (key_high_i),
    .key_low_i           (key_low_i),
    .version_in_i        (version_in_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .flag_out_o          (flag_out_o),
    .version_out_o       (version_out_o)
  );

endmodule

[hdl/brg_checker.sv]
// ----------------------------------------------------------------------------
// brg_checker
// port-level checks on the version rollback guard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic        flag_out_o,
  input logic [63:0] version_out_o
);

  logic vout_nz;
  logic st_ok;

  assign vout_nz = (version_out_o != 64'd0);
  assign st_ok   = (status_o == brg_pkg::ST_OK);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
  `ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= brg_pkg::ST_INVALID)
  `ASSERT_IMP(a_flag_ok, clk_i, rst_ni, out_valid_o && flag_out_o, st_ok)
  `ASSERT_IMP(a_vout_ok, clk_i, rst_ni, out_valid_o && vout_nz, st_ok && !flag_out_o)
  `ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)

endmodule

bind block_version_rollback_guard_core brg_checker u_brg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .flag_out_o    (flag_out_o),
  .version_out_o (version_out_o)
);

[dv/block_version_rollback_guard_core_tb.sv]
// ----------------------------------------------------------------------------
// block_version_rollback_guard_core_tb
// self-checking bench: directed table then random requests against a local
// model of the version and writer tables, under several idle/stall mixes and
// apb register settings, ending with a fill of both tables
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_version_rollback_guard_core_tb;

  localparam int          N_VER       = 256;
  localparam int          N_WR        = 256;
  localparam int          DRAIN_WAIT  = 300;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam logic [2:0]  ADDR_OWN    = 3'd0;
  localparam logic [2:0]  ADDR_DEL    = 3'd4;
  localparam logic [2:0]  FN_BAD_LO   = 3'd5;
  localparam logic [2:0]  FN_BAD_HI   = 3'd7;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          N_KEYS      = 24;

  typedef struct packed {
    logic [2:0]  status;
    logic        flag;
    logic [63:0] vout;
  } guard_result_t;

  typedef struct {
    logic [2:0]    func;
    logic [31:0]   cid;
    logic [63:0]   kh;
    logic [63:0]   kl;
    logic [63:0]   ver;
    bit            typed;
    guard_result_t res;
  } guard_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  func_i = '0;
  logic [31:0] client_id_i = '0;
  logic [63:0] key_high_i = '0;
  logic [63:0] key_low_i = '0;
  logic [63:0] version_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic        flag_out_o;
  logic [63:0] version_out_o;

  block_version_rollback_guard_core i_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // local copy of the tables and registers
  logic [31:0] own_id;
  logic [31:0] del_id;
  bit          vt_used [N_VER];
  logic [31:0] vt_cl   [N_VER];
  logic [63:0] vt_kh   [N_VER];
  logic [63:0] vt_kl   [N_VER];
  logic [63:0] vt_val  [N_VER];
  bit          wt_used [N_WR];
  logic [63:0] wt_kh   [N_WR];
  logic [63:0] wt_kl   [N_WR];
  logic [31:0] wt_cl   [N_WR];

  guard_result_t pending_results[$];
  int            err_cnt = 0;
  int            cycles = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            hold_cycles = 0;
  logic [63:0]   key_pool_h [N_KEYS];
  logic [63:0]   key_pool_l [N_KEYS];

  function automatic int ver_lookup(logic [31:0] c, logic [63:0] kh, logic [63:0] kl);
    for (int i = 0; i < N_VER; i++)
      if (vt_used[i] && vt_cl[i] == c && vt_kh[i] == kh && vt_kl[i] == kl) return i;
    return -1;
  endfunction

  function automatic int ver_slot();
    for (int i = 0; i < N_VER; i++) if (!vt_used[i]) return i;
    return -1;
  endfunction

  function automatic int wr_lookup(logic [63:0] kh, logic [63:0] kl);
    for (int i = 0; i < N_WR; i++)
      if (wt_used[i] && wt_kh[i] == kh && wt_kl[i] == kl) return i;
    return -1;
  endfunction

  function automatic int wr_slot();
    for (int i = 0; i < N_WR; i++) if (!wt_used[i]) return i;
    return -1;
  endfunction

  function automatic void ver_store(int s, logic [31:0] c, logic [63:0] kh, logic [63:0] kl,
                                    logic [63:0] v);
    vt_used[s] = 1'b1;
    vt_cl[s]   = c;
    vt_kh[s]   = kh;
    vt_kl[s]   = kl;
    vt_val[s]  = v;
  endfunction

  function automatic void wr_store(int s, logic [63:0] kh, logic [63:0] kl, logic [31:0] c);
    wt_used[s] = 1'b1;
    wt_kh[s]   = kh;
    wt_kl[s]   = kl;
    wt_cl[s]   = c;
  endfunction

  function automatic guard_result_t apply_request(logic [2:0] func, logic [31:0] cid,
                                                  logic [63:0] kh, logic [63:0] kl,
                                                  logic [63:0] ver);
    guard_result_t r;
    int            vs;
    int            ws;
    logic [63:0]   known;
    logic [63:0]   nv;
    bit            fresh;
    r = '0;
    r.status = brg_pkg::ST_OK;
    known = '0;
    fresh = 1'b0;
    case (func)
      brg_pkg::FN_CHECK_UPDATE: begin
        if (cid == del_id || ver == '0) begin
          r.status = brg_pkg::ST_INVALID;
          return r;
        end
        vs = ver_lookup(cid, kh, kl);
        if (vs < 0) begin
          vs = ver_slot();
          if (vs < 0) begin
            r.status = brg_pkg::ST_FULL;
            return r;
          end
        end else begin
          known = vt_val[vs];
          if (known > ver) begin
            r.status = brg_pkg::ST_REJECT;
            return r;
          end
        end
        ws = wr_lookup(kh, kl);
        if (ws < 0) begin
          ws = wr_slot();
          if (ws < 0) begin
            r.status = brg_pkg::ST_FULL;
            return r;
          end
        end else if (known == ver && wt_cl[ws] != cid) begin
          r.status = brg_pkg::ST_REJECT;
          return r;
        end
        ver_store(vs, cid, kh, kl, ver);
        wr_store(ws, kh, kl, cid);
        r.flag = 1'b1;
      end
      brg_pkg::FN_INCREMENT: begin
        vs = ver_lookup(own_id, kh, kl);
        if (vs < 0) begin
          vs = ver_slot();
          if (vs < 0) begin
            r.status = brg_pkg::ST_FULL;
            return r;
          end
          fresh = 1'b1;
        end else begin
          known = vt_val[vs];
        end
        nv = (ver > known) ? ver : known;
        if (nv >= brg_pkg::VER_LIMIT) begin
          if (fresh) ver_store(vs, own_id, kh, kl, '0);
          r.status = brg_pkg::ST_OVERFLOW;
          return r;
        end
        nv = nv + 64'd1;
        ws = wr_lookup(kh, kl);
        if (ws < 0) begin
          ws = wr_slot();
          if (ws < 0) begin
            r.status = brg_pkg::ST_FULL;
            return r;
          end
        end
        ver_store(vs, own_id, kh, kl, nv);
        wr_store(ws, kh, kl, own_id);
        r.vout = nv;
      end
      brg_pkg::FN_GET_VERSION: begin
        vs = ver_lookup(cid, kh, kl);
        if (vs < 0) r.status = brg_pkg::ST_NOTFOUND;
        else r.vout = vt_val[vs];
      end
      brg_pkg::FN_MARK_DELETED: begin
        ws = wr_lookup(kh, kl);
        if (ws < 0) begin
          ws = wr_slot();
          if (ws < 0) begin
            r.status = brg_pkg::ST_FULL;
            return r;
          end
        end
        wr_store(ws, kh, kl, del_id);
      end
      brg_pkg::FN_SHOULD_EXIST: begin
        ws = wr_lookup(kh, kl);
        r.flag = (ws >= 0 && wt_cl[ws] != del_id);
      end
      default: r.status = brg_pkg::ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic send_request(guard_row_t row);
    guard_result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= row.func;
    client_id_i  <= row.cid;
    key_high_i   <= row.kh;
    key_low_i    <= row.kl;
    version_in_i <= row.ver;
    do @(posedge clk_i); while (in_stall_o);
    r = apply_request(row.func, row.cid, row.kh, row.kl, row.ver);
    pending_results.push_back(row.typed ? row.res : r);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_OWN) own_id = data;
    else del_id = data;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_client();
    case ($urandom_range(9))
      0, 1: return own_id;
      2:    return del_id;
      3:    return $urandom();
      default: return $urandom_range(3);
    endcase
  endfunction

  function automatic logic [63:0] pick_version();
    case ($urandom_range(9))
      0: return {$urandom(), $urandom()};
      1: return ALL_ONES - $urandom_range(3);
      default: return $urandom_range(8);
    endcase
  endfunction

  function automatic guard_row_t random_row(bit fresh_key);
    guard_row_t row;
    int         k;
    int         p;
    p = $urandom_range(99);
    if (p < 35) row.func = brg_pkg::FN_CHECK_UPDATE;
    else if (p < 55) row.func = brg_pkg::FN_INCREMENT;
    else if (p < 70) row.func = brg_pkg::FN_GET_VERSION;
    else if (p < 80) row.func = brg_pkg::FN_MARK_DELETED;
    else if (p < 95) row.func = brg_pkg::FN_SHOULD_EXIST;
    else row.func = 3'($urandom_range(FN_BAD_LO, FN_BAD_HI));
    row.cid = pick_client();
    k = $urandom_range(N_KEYS - 1);
    if (fresh_key || $urandom_range(9) == 0) begin
      row.kh = {$urandom(), $urandom()};
      row.kl = {$urandom(), $urandom()};
    end else begin
      row.kh = key_pool_h[k];
      row.kl = key_pool_l[k];
    end
    row.ver = pick_version();
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic guard_row_t drow(logic [2:0] func, logic [31:0] cid, logic [63:0] kh,
                                      logic [63:0] kl, logic [63:0] ver, bit typed,
                                      logic [2:0] st, logic fl, logic [63:0] vo);
    guard_row_t row;
    row.func = func;
    row.cid = cid;
    row.kh = kh;
    row.kl = kl;
    row.ver = ver;
    row.typed = typed;
    row.res = '{status: st, flag: fl, vout: vo};
    return row;
  endfunction

  // output checker
  always @(posedge clk_i) begin
    guard_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d flag %0d version %0h",
               status_o, flag_out_o, version_out_o);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o);
          err_cnt++;
        end
        if (flag_out_o !== e.flag) begin
          $error("flag_out expected %0d got %0d", e.flag, flag_out_o);
          err_cnt++;
        end
        if (version_out_o !== e.vout) begin
          $error("version_out expected %0h got %0h", e.vout, version_out_o);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    guard_row_t  dir_rows[$];
    logic [63:0] ka;
    logic [63:0] kb;
    own_id = 32'd1;
    del_id = 32'd0;
    for (int i = 0; i < N_VER; i++) vt_used[i] = 1'b0;
    for (int i = 0; i < N_WR; i++) wt_used[i] = 1'b0;
    for (int i = 0; i < N_KEYS; i++) begin
      key_pool_h[i] = {$urandom(), $urandom()};
      key_pool_l[i] = {$urandom(), $urandom()};
    end
    ka = key_pool_h[0];
    kb = key_pool_h[1];

    dir_rows.push_back(drow(brg_pkg::FN_GET_VERSION, 5, ka, 0, 0, 1,
                            brg_pkg::ST_NOTFOUND, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_SHOULD_EXIST, 5, ka, 0, 0, 1, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 0, ka, 0, 3, 1,
                            brg_pkg::ST_INVALID, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 5, ka, 0, 0, 1,
                            brg_pkg::ST_INVALID, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 5, ka, 0, 3, 1, brg_pkg::ST_OK, 1, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 5, ka, 0, 3, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 6, ka, 0, 3, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 5, ka, 0, 3, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, 5, ka, 0, 2, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_GET_VERSION, 5, ka, 0, 0, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_INCREMENT, 0, ka, 0, 0, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_INCREMENT, 0, ka, 0, 10, 0, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_INCREMENT, 0, kb, 0, ALL_ONES, 1,
                            brg_pkg::ST_OVERFLOW, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_GET_VERSION, 1, kb, 0, 0, 1, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_INCREMENT, 0, kb, 0, ALL_ONES - 2, 0,
                            brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_INCREMENT, 0, kb, 0, 0, 1,
                            brg_pkg::ST_OVERFLOW, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_MARK_DELETED, 0, ka, 0, 0, 1, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_SHOULD_EXIST, 0, ka, 0, 0, 1, brg_pkg::ST_OK, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_SHOULD_EXIST, 0, kb, 0, 0, 1, brg_pkg::ST_OK, 1, 0));
    dir_rows.push_back(drow(FN_BAD_LO, 5, ka, 0, 3, 1, brg_pkg::ST_INVALID, 0, 0));
    dir_rows.push_back(drow(FN_BAD_HI, 5, ka, 0, 3, 1, brg_pkg::ST_INVALID, 0, 0));
    dir_rows.push_back(drow(brg_pkg::FN_CHECK_UPDATE, '1, ALL_ONES, ALL_ONES, ALL_ONES, 1,
                            brg_pkg::ST_OK, 1, 0));
    dir_rows.push_back(drow(brg_pkg::FN_GET_VERSION, '1, ALL_ONES, ALL_ONES, 0, 1,
                            brg_pkg::ST_OK, 0, ALL_ONES));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          apb_write(ADDR_OWN, 32'd3); apb_write(ADDR_DEL, 32'd2);
          idle_pct = 50; stall_pct = 0;
        end
        2: begin
          apb_write(ADDR_OWN, 32'd0); apb_write(ADDR_DEL, 32'hFFFF_FFFF);
          idle_pct = 0; stall_pct = 50;
        end
        3: begin
          apb_write(ADDR_OWN, 32'hFFFF_FFFF); apb_write(ADDR_DEL, 32'd0);
          idle_pct = 21; stall_pct = 21;
        end
        default: begin
          apb_write(ADDR_OWN, 32'd2); apb_write(ADDR_DEL, 32'd1);
          idle_pct = 21; stall_pct = 21;
        end
      endcase
      for (int n = 0; n < ((ph == 4) ? 320 : 120); n++) begin
        if (ph == 2 && n == 10) hold_cycles = 3000;
        // last phase mostly creates new keys so both tables run full
        send_request(random_row(ph == 4 && $urandom_range(9) < 8));
      end
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
